@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros used by the top-level RTL module.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define LGE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define LGE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error(msg);

`endif

@@ hw/rtl/lge_pkg.sv @@
// Shared constants, types and helper functions of the life generation engine.
// Depends on nothing; used by the interfaces and every module.
`default_nettype none

package lge_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int DEATH_AGE  = 10;
    localparam int SURVIVE_LO = 2;
    localparam int BIRTH_CNT  = 3;

    localparam int AGE_W      = 4;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int SIZE_W     = 7;
    localparam int ACT_W      = 2;
    localparam int IDX_FLD_W  = 6;
    localparam int BITS_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CNT_W      = 4;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GEN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd3;

    typedef logic [MAX_COLS-1:0][AGE_W-1:0] row_ages_t;
    typedef logic [MAX_COLS-1:0]            row_live_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
    } mem_cmd_t;

    // Live flags of a row of ages
    function automatic row_live_t live_of(input row_ages_t ages);
        row_live_t v;
        for (int c = 0; c < MAX_COLS; c++) begin
            v[c] = |ages[c];
        end
        return v;
    endfunction

    // Bring a size register into 1..lim
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lge_req_if.sv @@
// Request channel of the life generation engine: action, row, column, row bits.
// Depends on lge_pkg.
`default_nettype none

interface lge_req_if;
    logic                            valid;
    logic                            ready;
    logic [lge_pkg::ACT_W-1:0]       action;
    logic [lge_pkg::IDX_FLD_W-1:0]   row_index;
    logic [lge_pkg::IDX_FLD_W-1:0]   col_index;
    logic [lge_pkg::BITS_W-1:0]      row_bits;

    modport source (output valid, action, row_index, col_index, row_bits, input ready);
    modport sink   (input valid, action, row_index, col_index, row_bits, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lge_res_if.sv @@
// Result channel of the life generation engine: live bits, cell age, done flag.
// Depends on lge_pkg.
`default_nettype none

interface lge_res_if;
    logic                          valid;
    logic                          ready;
    logic [lge_pkg::BITS_W-1:0]    live_bits;
    logic [lge_pkg::AGE_W-1:0]     cell_age;
    logic                          done_res;

    modport source (output valid, live_bits, cell_age, done_res, input ready);
    modport sink   (input valid, live_bits, cell_age, done_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lge_cfg_if.sv @@
// Configuration write channel of the life generation engine.
// Depends on lge_pkg.
`default_nettype none

interface lge_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lge_pkg::CFG_IDX_W-1:0]     index;
    logic [lge_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lge_grid_store.sv @@
// Row-wide store of cell ages: one write and one registered read per cycle.
// Depends on lge_pkg. Rows never written since reset read as all zero.
`default_nettype none

module lge_grid_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lge_pkg::mem_cmd_t  cmd,
    input  wire lge_pkg::row_ages_t wr_data,
    output lge_pkg::row_ages_t      rd_data
);

    lge_pkg::row_ages_t            mem [lge_pkg::MAX_ROWS];
    logic [lge_pkg::MAX_ROWS-1:0]  row_valid_reg;
    lge_pkg::row_ages_t            rd_q_reg;
    logic                          rd_valid_reg;

    // Row written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[cmd.rd_addr];
            end
        end
    end

    // Storage array
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[cmd.rd_addr];
        end
    end

    // Mask rows that hold no data yet
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

@@ hw/rtl/lge_row_rule.sv @@
// One full row of cell rules: neighbour count, birth/survival and ageing.
// Depends on lge_pkg.
`default_nettype none

module lge_row_rule (
    input  wire logic                        wrap,
    input  wire logic                        aging,
    input  wire logic [lge_pkg::SIZE_W-1:0]  n_cols,
    input  wire lge_pkg::row_live_t          up_live,
    input  wire lge_pkg::row_ages_t          cur_ages,
    input  wire lge_pkg::row_live_t          dn_live,
    output lge_pkg::row_ages_t               new_ages
);

    lge_pkg::row_live_t            cur_live;
    logic [lge_pkg::COL_W-1:0]     last_col;
    logic [2:0]                    last_trio;
    logic [2:0]                    first_trio;

    assign cur_live   = lge_pkg::live_of(cur_ages);
    assign last_col   = lge_pkg::COL_W'(n_cols - lge_pkg::SIZE_W'(1));
    assign last_trio  = {up_live[last_col], cur_live[last_col], dn_live[last_col]};
    assign first_trio = {up_live[0], cur_live[0], dn_live[0]};

    for (genvar c = 0; c < lge_pkg::MAX_COLS; c++)
    begin : g_lane
        logic [2:0]                  lft;
        logic [2:0]                  rgt;
        logic                        last_lane;
        logic                        in_use;
        logic [lge_pkg::CNT_W-1:0]   cnt;
        logic [lge_pkg::AGE_W-1:0]   ruled;
        logic [lge_pkg::AGE_W:0]     aged;

        assign last_lane = (lge_pkg::COL_W'(c) == last_col);
        assign in_use    = (lge_pkg::SIZE_W'(c) < n_cols);

        // Left neighbours, wrapping to the last column in use
        if (c == 0)
        begin : g_lft_edge
            assign lft = wrap ? last_trio : 3'b000;
        end
        else
        begin : g_lft_mid
            assign lft = {up_live[c-1], cur_live[c-1], dn_live[c-1]};
        end

        // Right neighbours, wrapping to column zero
        if (c == lge_pkg::MAX_COLS - 1)
        begin : g_rgt_edge
            assign rgt = wrap ? first_trio : 3'b000;
        end
        else
        begin : g_rgt_mid
            assign rgt = last_lane ? (wrap ? first_trio : 3'b000)
                                   : {up_live[c+1], cur_live[c+1], dn_live[c+1]};
        end

        assign cnt = lge_pkg::CNT_W'(up_live[c]) + lge_pkg::CNT_W'(dn_live[c])
                   + lge_pkg::CNT_W'(lft[0]) + lge_pkg::CNT_W'(lft[1])
                   + lge_pkg::CNT_W'(lft[2]) + lge_pkg::CNT_W'(rgt[0])
                   + lge_pkg::CNT_W'(rgt[1]) + lge_pkg::CNT_W'(rgt[2]);

        // Birth on three, survival on two or three
        always_comb
        begin
            if (cur_live[c])
            begin
                if (cnt == lge_pkg::CNT_W'(lge_pkg::SURVIVE_LO)
                    || cnt == lge_pkg::CNT_W'(lge_pkg::BIRTH_CNT))
                    ruled = cur_ages[c];
                else
                    ruled = '0;
            end
            else
            begin
                ruled = (cnt == lge_pkg::CNT_W'(lge_pkg::BIRTH_CNT))
                        ? lge_pkg::AGE_W'(1) : '0;
            end
        end

        assign aged = {1'b0, ruled} + (lge_pkg::AGE_W+1)'(1);

        // Age living cells when ageing is on; leave columns outside the grid untouched
        always_comb
        begin
            if (!in_use)
                new_ages[c] = cur_ages[c];
            else if (aging && ruled != '0)
                new_ages[c] = (aged >= (lge_pkg::AGE_W+1)'(lge_pkg::DEATH_AGE))
                              ? '0 : aged[lge_pkg::AGE_W-1:0];
            else
                new_ages[c] = ruled;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/life_generation_engine.sv @@
// Top level of the life generation engine: request sequencer and registers.
// Depends on lge_pkg, the three channel interfaces, lge_grid_store, lge_row_rule.
//
//   channel  modport  moves
//   cfg      sink     register index and value, always ready
//   req      sink     action, row_index, col_index, row_bits
//   res      source   live_bits, cell_age, done_res
//
// A row write reads, then writes the merged row; a row read reads, then captures the
// result. A generation reads row zero and the last row, then reads and updates each
// row in turn through the single row read port of the grid store.
// No clearing pass after reset: unwritten rows read as zero.
// The next request is taken once the result sits in the output register.
// A stalled result holds the block in its hand-over state.
`default_nettype none
`include "assert_macros.svh"

module life_generation_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lge_cfg_if.sink    cfg,
    lge_req_if.sink    req,
    lge_res_if.source  res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WRD  = 4'd1;
    localparam logic [3:0] S_WWR  = 4'd2;
    localparam logic [3:0] S_RRD  = 4'd3;
    localparam logic [3:0] S_RRES = 4'd4;
    localparam logic [3:0] S_G0   = 4'd5;
    localparam logic [3:0] S_G1   = 4'd6;
    localparam logic [3:0] S_G2   = 4'd7;
    localparam logic [3:0] S_GR   = 4'd8;
    localparam logic [3:0] S_GC   = 4'd9;
    localparam logic [3:0] S_PUSH = 4'd10;

    localparam logic [lge_pkg::ACT_W-1:0] ACT_WRITE_C = lge_pkg::ACT_WRITE;
    localparam logic [lge_pkg::ACT_W-1:0] ACT_GEN_C   = lge_pkg::ACT_GEN;
    localparam logic [lge_pkg::ACT_W-1:0] ACT_READ_C  = lge_pkg::ACT_READ;

    logic [3:0]                      state_reg, state_next;
    logic                            wrap_reg, aging_reg;
    logic [lge_pkg::SIZE_W-1:0]      rows_reg, cols_reg;
    logic [lge_pkg::ROW_W-1:0]       r_reg, r_next;
    logic                            out_valid_reg, out_valid_next;

    logic [lge_pkg::ACT_W-1:0]       act_reg;
    logic [lge_pkg::IDX_FLD_W-1:0]   row_reg;
    logic [lge_pkg::IDX_FLD_W-1:0]   col_reg;
    logic [lge_pkg::BITS_W-1:0]      bits_reg;
    lge_pkg::row_ages_t              cur_reg;
    lge_pkg::row_live_t              prev_live_reg, first_live_reg, last_live_reg;
    logic [lge_pkg::BITS_W-1:0]      res_live_reg, out_live_reg;
    logic [lge_pkg::AGE_W-1:0]       res_age_reg, out_age_reg;
    logic                            res_done_reg, out_done_reg;

    logic [lge_pkg::SIZE_W-1:0]      n_rows, n_cols;
    logic [lge_pkg::ROW_W-1:0]       last_row;
    logic                            req_accept, push_ok, row_ok, col_ok, r_last;
    lge_pkg::row_live_t              col_mask, up_live, dn_live;
    lge_pkg::row_ages_t              rd_data, wr_data, merged, gen_row;
    lge_pkg::mem_cmd_t               mem_cmd;

    assign n_rows   = lge_pkg::clamp_size(rows_reg, lge_pkg::SIZE_W'(lge_pkg::MAX_ROWS));
    assign n_cols   = lge_pkg::clamp_size(cols_reg, lge_pkg::SIZE_W'(lge_pkg::MAX_COLS));
    assign last_row = lge_pkg::ROW_W'(n_rows - lge_pkg::SIZE_W'(1));
    assign row_ok   = lge_pkg::SIZE_W'(row_reg) < n_rows;
    assign col_ok   = lge_pkg::SIZE_W'(col_reg) < n_cols;
    assign r_last   = (r_reg == last_row);

    assign cfg.ready  = 1'b1;
    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign push_ok    = (state_reg == S_PUSH) && (!out_valid_reg || res.ready);

    assign res.valid     = out_valid_reg;
    assign res.live_bits = out_live_reg;
    assign res.cell_age  = out_age_reg;
    assign res.done_res  = out_done_reg;

    // Columns in use
    always_comb
    begin
        for (int c = 0; c < lge_pkg::MAX_COLS; c++)
        begin
            col_mask[c] = lge_pkg::SIZE_W'(c) < n_cols;
        end
    end

    // Merge written bits into the columns in use
    always_comb
    begin
        for (int c = 0; c < lge_pkg::MAX_COLS; c++)
        begin
            merged[c] = col_mask[c] ? lge_pkg::AGE_W'(bits_reg[c]) : rd_data[c];
        end
    end

    // Rows above and below the one being updated
    assign up_live = (r_reg == '0) ? (wrap_reg ? last_live_reg : '0) : prev_live_reg;
    assign dn_live = r_last ? (wrap_reg ? first_live_reg : '0) : lge_pkg::live_of(rd_data);

    lge_row_rule u_rule (
        .wrap     (wrap_reg),
        .aging    (aging_reg),
        .n_cols   (n_cols),
        .up_live  (up_live),
        .cur_ages (cur_reg),
        .dn_live  (dn_live),
        .new_ages (gen_row)
    );

    // Grid store commands
    always_comb
    begin
        mem_cmd = '0;
        wr_data = gen_row;
        case (state_reg)
            S_WRD, S_RRD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = lge_pkg::ROW_W'(row_reg);
            end
            S_WWR:
            begin
                mem_cmd.wr_en   = row_ok;
                mem_cmd.wr_addr = lge_pkg::ROW_W'(row_reg);
                wr_data         = merged;
            end
            S_G0:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = '0;
            end
            S_G1:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = last_row;
            end
            S_GR:
            begin
                mem_cmd.rd_en   = !r_last;
                mem_cmd.rd_addr = r_reg + lge_pkg::ROW_W'(1);
            end
            S_GC:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = r_reg;
            end
            default:
            begin
                mem_cmd = '0;
            end
        endcase
    end

    lge_grid_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    case (req.action)
                        ACT_WRITE_C: state_next = S_WRD;
                        ACT_GEN_C:   state_next = S_G0;
                        ACT_READ_C:  state_next = S_RRD;
                        default:     state_next = S_PUSH;
                    endcase
                end
            end
            S_WRD:  state_next = S_WWR;
            S_WWR:  state_next = S_PUSH;
            S_RRD:  state_next = S_RRES;
            S_RRES: state_next = S_PUSH;
            S_G0:   state_next = S_G1;
            S_G1:   state_next = S_G2;
            S_G2:
            begin
                r_next     = '0;
                state_next = S_GR;
            end
            S_GR:   state_next = S_GC;
            S_GC:
            begin
                if (r_last)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    r_next     = r_reg + lge_pkg::ROW_W'(1);
                    state_next = S_GR;
                end
            end
            S_PUSH:
            begin
                if (push_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output slot: load on hand-over, drop when taken
    always_comb
    begin
        if (push_ok)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            wrap_reg      <= 1'b1;
            aging_reg     <= 1'b0;
            rows_reg      <= lge_pkg::SIZE_W'(lge_pkg::MAX_ROWS);
            cols_reg      <= lge_pkg::SIZE_W'(lge_pkg::MAX_COLS);
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    lge_pkg::CFG_WRAP:  wrap_reg  <= cfg.data[0];
                    lge_pkg::CFG_AGING: aging_reg <= cfg.data[0];
                    lge_pkg::CFG_ROWS:  rows_reg  <= cfg.data;
                    lge_pkg::CFG_COLS:  cols_reg  <= cfg.data;
                    default:            wrap_reg  <= wrap_reg;
                endcase
            end
        end
    end

    // Request, row window and result payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            act_reg      <= req.action;
            row_reg      <= req.row_index;
            col_reg      <= req.col_index;
            bits_reg     <= req.row_bits;
            res_live_reg <= '0;
            res_age_reg  <= '0;
            res_done_reg <= (req.action == ACT_WRITE_C) || (req.action == ACT_GEN_C)
                            || (req.action == ACT_READ_C);
        end
        if (state_reg == S_RRES && act_reg == ACT_READ_C && row_ok)
        begin
            res_live_reg <= lge_pkg::live_of(rd_data) & col_mask;
            res_age_reg  <= col_ok ? rd_data[lge_pkg::COL_W'(col_reg)] : '0;
        end
        if (state_reg == S_G1)
        begin
            cur_reg        <= rd_data;
            first_live_reg <= lge_pkg::live_of(rd_data);
        end
        if (state_reg == S_G2)
        begin
            last_live_reg <= lge_pkg::live_of(rd_data);
        end
        if (state_reg == S_GC)
        begin
            prev_live_reg <= lge_pkg::live_of(cur_reg);
            cur_reg       <= rd_data;
        end
        if (push_ok)
        begin
            out_live_reg <= res_live_reg;
            out_age_reg  <= res_age_reg;
            out_done_reg <= res_done_reg;
        end
    end

    `LGE_ASSERT(a_accept_leaves_idle, clk, rst_n, req_accept |=> (state_reg != S_IDLE), "request accepted but sequencer stayed idle")
    `LGE_ASSERT(a_write_when_busy, clk, rst_n, mem_cmd.wr_en |-> (state_reg == S_WWR || state_reg == S_GC), "grid write outside a write or update step")
    `LGE_ASSERT(a_result_from_push, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == S_PUSH), "result appeared without a hand-over")

endmodule

`default_nettype wire
